>>> rtl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DQE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double_ended_queue check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define DQE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double_ended_queue check failed");

`endif

>>> rtl/dqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Field widths, request kinds, status codes and cell commands.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRITE_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

endpackage

>>> rtl/dqe_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
interface dqe_req_if import dqe_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

>>> rtl/dqe_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel carrying one result of a queue operation.
// ----------------------------------------------------------------------------
interface dqe_rsp_if import dqe_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, entry_value, status, last, input ready);
  modport sink   (input valid, entry_value, status, last, output ready);
endinterface

>>> rtl/dqe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One entry slot; loads from its neighbors, the head or the request value.
// ----------------------------------------------------------------------------
module dqe_cell import dqe_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = $clog2(CAPACITY_DEF + 1)
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic signed [DATA_W-1:0] head_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [CNT_W-1:0] POS    = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(INDEX + 1);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_SHIFT_UP: begin
        data_next = (INDEX == 0) ? cmd.value : prev_data;
      end
      CELL_SHIFT_DOWN: begin
        data_next = next_data;
      end
      CELL_WRITE_BACK: begin
        if (count == POS) data_next = cmd.value;
      end
      CELL_ROTATE: begin
        if (count == POS_P1) begin
          data_next = head_data;
        end else if (POS_P1 < count) begin
          data_next = next_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign tap = (count == POS_P1) ? data : '0;

endmodule

>>> rtl/dqe_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue cell chain
// Row of entry cells, front at cell zero; yields the head and tail entries.
// ----------------------------------------------------------------------------
module dqe_chain import dqe_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]         count,
  output logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0] tail
);

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_d;
    logic signed [DATA_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    dqe_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  assign head = cell_data[0];

  always_comb begin
    tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail = tail | cell_tap[i];
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed entries held in a shifting row of cells.
//
//   channel  dir  fields
//   req      in   kind, push_value
//   rsp      out  entry_value, status, last
//
// Push and pop give one response each.
// List gives one response per entry, rotating the row one cell a cycle while
// the output is free; requests are held off until the last entry is out.
// Entry order lives in the cell row, so reset clears only count and control.
// A stalled response holds the output register and with it the request side.
// ----------------------------------------------------------------------------
module double_ended_queue import dqe_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic     clk,
  input logic     rst,
  dqe_req_if.sink req,
  dqe_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         remaining, remaining_next;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  status_t                  out_status;
  logic                     out_last;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W-1:0] tail;
  logic                     slot_free;
  logic                     is_full;
  logic                     is_empty;
  logic                     load;
  logic signed [DATA_W-1:0] load_value;
  status_t                  load_status;
  logic                     load_last;

  dqe_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count),
    .head  (head),
    .tail  (tail)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign is_full   = (count == CNT_FULL);
  assign is_empty  = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    cmd.op         = CELL_HOLD;
    cmd.value      = req.push_value;
    load           = 1'b0;
    load_value     = '0;
    load_status    = STATUS_OK;
    load_last      = 1'b1;
    req.ready      = (state == ST_IDLE) && slot_free;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && slot_free) begin
          unique case (req.kind)
            KIND_PUSH_FRONT: begin
              load = 1'b1;
              if (is_full) begin
                load_status = STATUS_FULL;
              end else begin
                cmd.op     = CELL_SHIFT_UP;
                count_next = count + CNT_ONE;
              end
            end
            KIND_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                load_status = STATUS_FULL;
              end else begin
                cmd.op     = CELL_WRITE_BACK;
                count_next = count + CNT_ONE;
              end
            end
            KIND_POP_FRONT: begin
              load = 1'b1;
              if (is_empty) begin
                load_status = STATUS_EMPTY;
              end else begin
                load_value = head;
                cmd.op     = CELL_SHIFT_DOWN;
                count_next = count - CNT_ONE;
              end
            end
            KIND_POP_BACK: begin
              load = 1'b1;
              if (is_empty) begin
                load_status = STATUS_EMPTY;
              end else begin
                load_value = tail;
                count_next = count - CNT_ONE;
              end
            end
            KIND_LIST: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = STATUS_EMPTY;
              end else begin
                remaining_next = count;
                state_next     = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          cmd.op         = CELL_ROTATE;
          load           = 1'b1;
          load_value     = head;
          load_last      = (remaining == CNT_ONE);
          remaining_next = remaining - CNT_ONE;
          if (remaining == CNT_ONE) state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= load_value;
      out_status <= load_status;
      out_last   <= load_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.entry_value = out_value;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;

  `include "double_ended_queue_assert.svh"

  `DQE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_FULL)
  `DQE_ASSERT_NOW(a_list_blocks_req, state == ST_LIST, !req.ready)
  `DQE_ASSERT_NEXT(a_push_front_grows,
    req.valid && req.ready && req.kind == KIND_PUSH_FRONT && !is_full,
    count == $past(count) + CNT_ONE)
  `DQE_ASSERT_NOW(a_full_is_last, rsp.valid && rsp.status == STATUS_FULL, rsp.last)

endmodule
